### hw/rtl/fixed_point_to_best_fraction_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the best-fraction block and its checker
// Two concurrent assertion forms: same-cycle and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_TO_BEST_FRACTION_ASSERT_SVH
`define FIXED_POINT_TO_BEST_FRACTION_ASSERT_SVH

// Consequent must hold in the cycle of the antecedent
`define FPBF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define FPBF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/fpbf_pkg.sv
// ----------------------------------------------------------------------------
// fpbf_pkg
// Shared widths, reset values, sequencer states and control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpbf_pkg;

    // Field widths
    localparam int VAL_W  = 17;             // fixed-point input
    localparam int DEN_W  = 15;             // numerator / denominator / limit
    localparam int TREE_W = 16;             // tree terms, up to twice the limit
    localparam int PROD_W = VAL_W + TREE_W; // value times a denominator

    localparam logic [DEN_W-1:0] MAX_DEN_RST = 15'd255;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CMP
    } t_state;

    // Sequencer to step unit
    typedef struct packed {
        logic load;    // seed bounds 0/1 and 1/1
        logic eval;    // form mediant and value * mediant denominator
        logic cmp;     // compare phase, narrow bounds on a miss
        logic finish;  // capture the selected fraction
    } t_step_ctl;

    // Step unit to sequencer
    typedef struct packed {
        logic in_range; // both bound denominators within the limit
        logic eq;       // mediant truncates to the input value
    } t_step_sts;

endpackage

### hw/rtl/fpbf_step.sv
// ----------------------------------------------------------------------------
// fpbf_step
// Stern-Brocot step unit: holds the bounds, forms the mediant and compares
// its truncated fixed-point value with the input by cross multiplication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpbf_step
    import fpbf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic [VAL_W-1:0] i_value,
    input  logic [DEN_W-1:0] i_lim,
    input  t_step_ctl        i_ctl,
    output t_step_sts        o_sts,
    output logic [DEN_W-1:0] o_num,
    output logic [DEN_W-1:0] o_den
);

    // Compare width covers mediant numerator scaled and (x+1)*md
    localparam int CW = (TREE_W + FRAC_BITS > PROD_W + 1) ?
                        (TREE_W + FRAC_BITS) : (PROD_W + 1);

    // Bounds lo = a/b, hi = c/d; x*b and x*d tracked by addition
    logic [TREE_W-1:0] r_a, r_b, r_c, r_d;
    logic [PROD_W-1:0] r_xb, r_xd;
    // Mediant and x * mediant denominator
    logic [TREE_W-1:0] r_mn, r_md;
    logic [PROD_W-1:0] r_p;

    logic [TREE_W-1:0] w_lim;
    logic [CW-1:0]     w_target;
    logic [CW-1:0]     w_lo_prod;
    logic [CW-1:0]     w_hi_prod;
    logic              w_gt;
    logic              w_lt;
    logic              w_eq;

    assign w_lim = {1'b0, i_lim};

    // m = floor(mn*2^F/md): x > m iff x*md > mn*2^F,
    // x < m iff (x+1)*md <= mn*2^F
    assign w_target  = CW'({r_mn, {FRAC_BITS{1'b0}}});
    assign w_lo_prod = CW'(r_p);
    assign w_hi_prod = CW'(r_p) + CW'(r_md);
    assign w_gt      = (w_lo_prod > w_target);
    assign w_lt      = (w_hi_prod <= w_target);
    assign w_eq      = !w_gt && !w_lt;

    assign o_sts.in_range = (r_b <= w_lim) && (r_d <= w_lim);
    assign o_sts.eq       = w_eq;

    // Bound and mediant registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a  <= '0;
            r_b  <= TREE_W'(1);
            r_c  <= TREE_W'(1);
            r_d  <= TREE_W'(1);
            r_xb <= PROD_W'(i_value);
            r_xd <= PROD_W'(i_value);
        end else if (i_ctl.cmp && !w_eq) begin
            if (w_gt) begin
                r_a  <= r_mn;
                r_b  <= r_md;
                r_xb <= r_p;
            end else begin
                r_c  <= r_mn;
                r_d  <= r_md;
                r_xd <= r_p;
            end
        end
        if (i_ctl.eval) begin
            r_mn <= r_a + r_c;
            r_md <= r_b + r_d;
            r_p  <= r_xb + r_xd;
        end
    end

    // Result pick: exact hit in compare phase, limit overrun otherwise
    always_comb begin
        o_num = r_a[DEN_W-1:0];
        o_den = r_b[DEN_W-1:0];
        if (i_ctl.cmp) begin
            if (r_md <= w_lim) begin
                o_num = r_mn[DEN_W-1:0];
                o_den = r_md[DEN_W-1:0];
            end else if (r_d > r_b) begin
                o_num = r_c[DEN_W-1:0];
                o_den = r_d[DEN_W-1:0];
            end
        end else if (r_b > w_lim) begin
            o_num = r_c[DEN_W-1:0];
            o_den = r_d[DEN_W-1:0];
        end
    end

endmodule

### hw/rtl/fpbf_ctrl.sv
// ----------------------------------------------------------------------------
// fpbf_ctrl
// Sequencer: alternates mediant evaluation and compare until the walk ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpbf_ctrl
    import fpbf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_step_sts i_sts,
    output t_step_ctl o_ctl,
    output logic      o_busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and step controls
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!i_sts.in_range) begin
                    o_ctl.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_ctl.eval = 1'b1;
                    n_state    = ST_CMP;
                end
            end
            ST_CMP: begin
                o_ctl.cmp = 1'b1;
                if (i_sts.eq) begin
                    o_ctl.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    n_state = ST_EVAL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

### hw/rtl/fixed_point_to_best_fraction.sv
// A transaction starts when start is high and busy is low; busy then stays
// high until the result is ready. Each Stern-Brocot step runs in the single
// step unit as an EVAL state that forms the mediant and a CMP state that
// compares it against the input. o_valid is registered from the finish
// control and rises after the compare that hits the input exactly, or after
// the walk stops on the limit. The number of steps is at most about
// max_denominator. The result is on the ports for exactly one cycle and
// cannot be stalled; capture it when o_valid is high. A new start is accepted
// in the cycle the result is shown. Write max_denominator only while busy is
// low.
// ----------------------------------------------------------------------------
// fixed_point_to_best_fraction
// Best coprime fraction num/den, den <= max_denominator, for a fixed-point
// value in [0,1], found by walking the Stern-Brocot tree.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_point_to_best_fraction
    import fpbf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [VAL_W-1:0] i_fixed_value,
    input  logic             i_cfg_we,
    input  logic [DEN_W-1:0] i_cfg_wdata,
    output logic             o_valid,
    output logic [DEN_W-1:0] o_numerator,
    output logic [DEN_W-1:0] o_denominator
);

    logic [DEN_W-1:0] r_max_den;
    logic             r_valid;
    logic [DEN_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;

    t_step_ctl        w_ctl;
    t_step_sts        w_sts;
    logic [DEN_W-1:0] w_num;
    logic [DEN_W-1:0] w_den;

    // Denominator limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_den <= MAX_DEN_RST;
        end else if (i_cfg_we) begin
            r_max_den <= i_cfg_wdata;
        end
    end

    fpbf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (busy)
    );

    fpbf_step #(
        .FRAC_BITS (FRAC_BITS)
    ) u_step (
        .i_clk   (i_clk),
        .i_value (i_fixed_value),
        .i_lim   (r_max_den),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_ctl.finish;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_ctl.finish) begin
            r_num <= w_num;
            r_den <= w_den;
        end
    end

    assign o_valid       = r_valid;
    assign o_numerator   = r_num;
    assign o_denominator = r_den;

endmodule

### hw/rtl/fpbf_checker.sv
// ----------------------------------------------------------------------------
// fpbf_checker
// Port-level checks on transaction sequencing and result sanity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_point_to_best_fraction_assert.svh"

module fpbf_checker
    import fpbf_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_valid,
    input logic [DEN_W-1:0] o_numerator,
    input logic [DEN_W-1:0] o_denominator
);

    // Accepted transaction makes the block busy
    `FPBF_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "start not taken")
    // Every result follows a busy period and ends it
    `FPBF_ASSERT_NOW(a_valid_end, i_clk, i_rst_n, o_valid, !busy && $past(busy), "stray result")
    // One result per transaction, never back to back
    `FPBF_ASSERT_NXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid, "result repeated")
    // Result is a fraction in [0,1] with a nonzero denominator
    `FPBF_ASSERT_NOW(a_frac_range, i_clk, i_rst_n, o_valid, (o_denominator != '0) && (o_numerator <= o_denominator), "bad fraction")

endmodule

bind fixed_point_to_best_fraction fpbf_checker u_fpbf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_numerator   (o_numerator),
    .o_denominator (o_denominator)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the best-fraction block against its own Stern-Brocot predictor.
// A short table of directed values and limits is walked first. Random
// values then follow over several denominator limits. Results are compared
// field by field in order of arrival.
// ----------------------------------------------------------------------------

module testbench;
    import fpbf_pkg::*;

    localparam int FRAC_BITS      = 16;
    localparam int WATCHDOG_LIMIT = 400000;
    localparam int RAND_PHASES    = 10;
    localparam int PHASE_ITEMS    = 190;
    localparam int MAX_REPORTS    = 10;

    localparam logic [VAL_W-1:0] VAL_ONE   = VAL_W'(1) << FRAC_BITS;
    localparam logic [DEN_W-1:0] LIMIT_TOP = '1;

    typedef struct packed {
        logic [DEN_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_fraction;

    // Directed table: a row either writes the limit or sends one value
    typedef enum logic {
        ROW_LIMIT,
        ROW_VALUE
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [VAL_W-1:0] value;  // value, or new limit for ROW_LIMIT
        logic             typed;  // expected fraction given in the row
        t_fraction        want;
    } t_row;

    localparam int DIR_ROWS = 26;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [VAL_W-1:0] i_fixed_value;
    logic             i_cfg_we;
    logic [DEN_W-1:0] i_cfg_wdata;
    logic             o_valid;
    logic [DEN_W-1:0] o_numerator;
    logic [DEN_W-1:0] o_denominator;

    logic [DEN_W-1:0] cur_limit = MAX_DEN_RST;
    bit               idle_en   = 1'b1;
    int               mismatches = 0;
    int               idle_cycles = 0;
    t_fraction        pending_fracs[$];

    t_row dir_rows [DIR_ROWS] = '{
        // reset limit of 255
        '{ROW_VALUE, 17'd0,      1'b1, {15'd0, 15'd1}},
        '{ROW_VALUE, 17'd65536,  1'b1, {15'd1, 15'd1}},
        '{ROW_VALUE, 17'd131071, 1'b1, {15'd1, 15'd1}},
        '{ROW_VALUE, 17'd65537,  1'b1, {15'd1, 15'd1}},
        '{ROW_VALUE, 17'd32768,  1'b1, {15'd1, 15'd2}},
        '{ROW_VALUE, 17'd21845,  1'b1, {15'd1, 15'd3}},
        '{ROW_VALUE, 17'd43690,  1'b1, {15'd2, 15'd3}},
        '{ROW_VALUE, 17'd1,      1'b0, '0},
        '{ROW_VALUE, 17'd65535,  1'b0, '0},
        // limit of zero: walk never starts
        '{ROW_LIMIT, 17'd0,      1'b0, '0},
        '{ROW_VALUE, 17'd12345,  1'b1, {15'd1, 15'd1}},
        '{ROW_VALUE, 17'd0,      1'b1, {15'd1, 15'd1}},
        '{ROW_VALUE, 17'd131071, 1'b1, {15'd1, 15'd1}},
        // limit of one: exact hit with mediant too large
        '{ROW_LIMIT, 17'd1,      1'b0, '0},
        '{ROW_VALUE, 17'd32768,  1'b0, '0},
        '{ROW_VALUE, 17'd0,      1'b1, {15'd0, 15'd1}},
        '{ROW_VALUE, 17'd65535,  1'b0, '0},
        // largest limit: longest walks
        '{ROW_LIMIT, 17'd32767,  1'b0, '0},
        '{ROW_VALUE, 17'd0,      1'b1, {15'd0, 15'd1}},
        '{ROW_VALUE, 17'd1,      1'b0, '0},
        '{ROW_VALUE, 17'd65535,  1'b0, '0},
        '{ROW_VALUE, 17'd65536,  1'b1, {15'd1, 15'd1}},
        '{ROW_VALUE, 17'd43690,  1'b1, {15'd2, 15'd3}},
        '{ROW_LIMIT, 17'd2,      1'b0, '0},
        '{ROW_VALUE, 17'd32768,  1'b1, {15'd1, 15'd2}},
        '{ROW_VALUE, 17'd10000,  1'b0, '0}
    };

    fixed_point_to_best_fraction #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_fixed_value(i_fixed_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (o_valid),
        .o_numerator  (o_numerator),
        .o_denominator(o_denominator)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stern-Brocot walk between 0/1 and 1/1 toward the truncated value
    function automatic t_fraction best_fraction(input logic [VAL_W-1:0] x,
                                                input logic [DEN_W-1:0] lim);
        longint unsigned lo_n, lo_d, hi_n, hi_d, med_n, med_d, trunc;
        t_fraction f;
        lo_n = 0;
        lo_d = 1;
        hi_n = 1;
        hi_d = 1;
        while (lo_d <= lim && hi_d <= lim) begin
            med_n = lo_n + hi_n;
            med_d = lo_d + hi_d;
            trunc = (med_n << FRAC_BITS) / med_d;
            if (trunc == x) begin
                // exact hit: mediant if it fits, else the deeper bound
                if (med_d <= lim) begin
                    f.num = DEN_W'(med_n);
                    f.den = DEN_W'(med_d);
                end else if (hi_d > lo_d) begin
                    f.num = DEN_W'(hi_n);
                    f.den = DEN_W'(hi_d);
                end else begin
                    f.num = DEN_W'(lo_n);
                    f.den = DEN_W'(lo_d);
                end
                return f;
            end else if (x > trunc) begin
                lo_n = med_n;
                lo_d = med_d;
            end else begin
                hi_n = med_n;
                hi_d = med_d;
            end
        end
        // limit passed: keep the bound that still fits
        if (lo_d > lim) begin
            f.num = DEN_W'(hi_n);
            f.den = DEN_W'(hi_d);
        end else begin
            f.num = DEN_W'(lo_n);
            f.den = DEN_W'(lo_d);
        end
        return f;
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Send one value; start may drop at random while waiting on busy
    task automatic send_value(input logic [VAL_W-1:0] x, input bit typed,
                              input t_fraction given);
        bit accepted;
        accepted = 1'b0;
        while (!accepted) begin
            @(negedge i_clk);
            i_fixed_value <= x;
            start         <= !idle_en || ($urandom_range(0, 99) >= 19);
            @(posedge i_clk);
            accepted = start && !busy;
        end
        pending_fracs.push_back(typed ? given : best_fraction(x, cur_limit));
    endtask

    // Limit write, only once every pending result has come back
    task automatic write_limit(input logic [DEN_W-1:0] lim);
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_fracs.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= lim;
        cur_limit   = lim;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Result check, in order of acceptance
    always @(posedge i_clk) begin : check_results
        t_fraction want;
        if (i_rst_n && o_valid) begin
            if (pending_fracs.size() == 0) begin
                note_mismatch($sformatf("unexpected result %0d/%0d",
                                        o_numerator, o_denominator));
            end else begin
                want = pending_fracs.pop_front();
                if (o_numerator !== want.num || o_denominator !== want.den)
                    note_mismatch($sformatf("expected %0d/%0d, got %0d/%0d",
                                            want.num, want.den,
                                            o_numerator, o_denominator));
            end
        end
    end

    // Watchdog on cycles with no transaction in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Stimulus
    initial begin : stimulus
        logic [DEN_W-1:0] lim;
        logic [VAL_W-1:0] x;
        int pick, q, p;

        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_fixed_value = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_LIMIT)
                write_limit(DEN_W'(dir_rows[i].value));
            else
                send_value(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
        end

        // random phases over a spread of limits; phase 3 never idles
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0, 5:    lim = MAX_DEN_RST;
                1, 6:    lim = DEN_W'($urandom_range(1, 8));
                2, 7:    lim = DEN_W'($urandom_range(9, 255));
                3, 8:    lim = DEN_W'($urandom_range(256, 2047));
                4:       lim = DEN_W'($urandom_range(2048, 32767));
                default: lim = LIMIT_TOP;
            endcase
            write_limit(lim);
            idle_en = (ph != 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8 && cur_limit <= 2047) begin
                    // near zero and near one: the long walks
                    case ($urandom_range(0, 5))
                        0:       x = '0;
                        1:       x = 17'd1;
                        2:       x = 17'd2;
                        3:       x = VAL_ONE - 17'd2;
                        4:       x = VAL_ONE - 17'd1;
                        default: x = VAL_ONE;
                    endcase
                end else if (pick < 16) begin
                    x = VAL_W'($urandom_range(VAL_ONE + 1, (1 << VAL_W) - 1));
                end else if (pick < 30) begin
                    // truncated simple fraction: exact hits
                    q = $urandom_range(1, 300);
                    p = $urandom_range(0, q);
                    x = VAL_W'((longint'(p) << FRAC_BITS) / q);
                end else begin
                    x = VAL_W'($urandom_range(0, VAL_ONE));
                end
                send_value(x, 1'b0, '0);
            end
        end

        // drain
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_fracs.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
